// File: design/mses_pkg.sv
// ----------------------------------------------------------------------------
// Sensor event scanner package
// Shared sizes, event codes, register indexes and the control and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mses_pkg;

  localparam int BUMPER_COUNT  = 5;
  localparam int BEACON_COUNT  = 4;
  localparam int TAPE_COUNT    = 5;
  localparam int MUX_POSITIONS = 5;
  localparam int SAMPLE_BITS   = 10;
  localparam int MAX_RESULTS   = 7;

  localparam int POS_W     = 3;
  localparam int NUM_W     = 3;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int TH_W      = 11;
  localparam int DIFF_W    = SAMPLE_BITS + 1;

  // Event sources in report order: bumper, beacon, then the tapes.
  localparam int SRC_BUMP   = 0;
  localparam int SRC_BEACON = 1;
  localparam int SRC_TAPE0  = 2;
  localparam int NSRC       = SRC_TAPE0 + TAPE_COUNT;
  localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] BUMPER_RESET_MASK = 8'h1F;
  localparam int         BUMPER_MASK_BITS  = 5;

  localparam logic [SAMPLE_BITS-1:0] BEACON_HIGH_RESET = 10'd600;
  localparam logic [SAMPLE_BITS-1:0] BEACON_LOW_RESET  = 10'd400;
  localparam logic signed [TH_W-1:0] TAPE_HIGH_RESET   = 11'sd200;
  localparam logic signed [TH_W-1:0] TAPE_LOW_RESET    = 11'sd100;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_BUMP_TRIP    = 3'd1,
    EV_BUMP_RELEASE = 3'd2,
    EV_BEACON_FOUND = 3'd3,
    EV_BEACON_LOST  = 3'd4,
    EV_TAPE_FOUND   = 3'd5,
    EV_TAPE_LOST    = 3'd6
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEACON_HIGH = 2'd0,
    REG_BEACON_LOW  = 2'd1,
    REG_TAPE_HIGH   = 2'd2,
    REG_TAPE_LOW    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic tape_eval;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic wrap;
    logic out_free;
    logic item_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/muxed_sensor_event_scanner_unit.sv
// ----------------------------------------------------------------------------
// Multiplexed sensor event scanner
// Top level: controller and datapath for bumper, beacon and tape events.
// ----------------------------------------------------------------------------
// Each input word is one read slot at the current multiplexer position. The
// block reports bump, beacon and tape events for it in that order, or a single
// none word, with the next mux position and LED state on every result word.
// A slot is accepted, then the tapes are scanned on the slot that wraps the
// position, and then each result word (one or two, or up to six on the
// wrapping slot) goes out through the output register; the emit sequencer
// drains one pending event per cycle while the output is not stalled.
// The next word is taken once the final result word is in the output register.
`default_nettype none

module muxed_sensor_event_scanner_unit
  import mses_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   bump_level,
  input  logic [SAMPLE_BITS-1:0] beacon_sample,
  input  logic [SAMPLE_BITS-1:0] tape_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             event_kind,
  output logic [NUM_W-1:0]       sensor_number,
  output logic [POS_W-1:0]       mux_select,
  output logic                   leds_on,
  output logic                   last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mses_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mses_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .bump_level    (bump_level),
    .beacon_sample (beacon_sample),
    .tape_sample   (tape_sample),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .sensor_number (sensor_number),
    .mux_select    (mux_select),
    .leds_on       (leds_on),
    .last          (last)
  );

endmodule

`default_nettype wire

// File: design/mses_ctrl.sv
// ----------------------------------------------------------------------------
// Sensor event scanner controller
// Sequences one read slot: accept, optional tape scan on a wrap, then one
// result word per cycle while the output is free, until the last one is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module mses_ctrl
  import mses_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TAPE = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.tape_eval = (state == S_TAPE);
    cmd.emit      = (state == S_EMIT) && status.out_free;
    in_stall      = (state != S_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          state_next = status.wrap ? S_TAPE : S_EMIT;
        end
      end
      S_TAPE: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.emit && status.item_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: design/mses_dp.sv
// ----------------------------------------------------------------------------
// Sensor event scanner datapath
// Holds thresholds, multiplexer position, LED phase and the per-sensor
// history, finds events, and drains them through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mses_dp
  import mses_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   bump_level,
  input  logic [SAMPLE_BITS-1:0] beacon_sample,
  input  logic [SAMPLE_BITS-1:0] tape_sample,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             event_kind,
  output logic [NUM_W-1:0]       sensor_number,
  output logic [POS_W-1:0]       mux_select,
  output logic                   leds_on,
  output logic                   last
);

  logic [SAMPLE_BITS-1:0]   beacon_high;
  logic [SAMPLE_BITS-1:0]   beacon_low;
  logic signed [TH_W-1:0]   tape_high;
  logic signed [TH_W-1:0]   tape_low;

  logic [POS_W-1:0]         mux_position;
  logic                     led_phase;
  logic                     bumper_last [BUMPER_COUNT];
  logic [SAMPLE_BITS-1:0]   beacon_last [BEACON_COUNT];
  logic [SAMPLE_BITS-1:0]   tape_dark   [TAPE_COUNT];
  logic [SAMPLE_BITS-1:0]   tape_lit    [TAPE_COUNT];
  logic signed [DIFF_W-1:0] tape_last_diff [TAPE_COUNT];

  logic [NSRC-1:0]          pending;
  event_kind_t              src_kind [NSRC];
  logic [POS_W-1:0]         acc_pos;
  logic [CNT_W-1:0]         emit_count;

  logic                     wrap;
  logic [POS_W-1:0]         pos_next;
  logic                     bump_hit;
  logic                     bump_old;
  logic                     beacon_hit;
  logic [SAMPLE_BITS-1:0]   beacon_old;
  logic                     beacon_found;
  logic                     beacon_lost;
  logic signed [DIFF_W-1:0] tape_diff  [TAPE_COUNT];
  logic                     tape_found [TAPE_COUNT];
  logic                     tape_lost  [TAPE_COUNT];

  logic                     sel_found;
  event_kind_t              sel_kind;
  logic [NUM_W-1:0]         sel_num;
  logic [NSRC-1:0]          rest;
  logic                     item_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      beacon_high <= BEACON_HIGH_RESET;
      beacon_low  <= BEACON_LOW_RESET;
      tape_high   <= TAPE_HIGH_RESET;
      tape_low    <= TAPE_LOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BEACON_HIGH: beacon_high <= cfg_data[SAMPLE_BITS-1:0];
        REG_BEACON_LOW:  beacon_low  <= cfg_data[SAMPLE_BITS-1:0];
        REG_TAPE_HIGH:   tape_high   <= $signed(cfg_data[TH_W-1:0]);
        REG_TAPE_LOW:    tape_low    <= $signed(cfg_data[TH_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Per-slot comparisons against the sensor at the current position.
  always_comb begin
    wrap       = (mux_position == POS_W'(MUX_POSITIONS - 1));
    pos_next   = wrap ? '0 : mux_position + 1'b1;
    bump_hit   = 1'b0;
    bump_old   = 1'b1;
    beacon_hit = 1'b0;
    beacon_old = '0;
    for (int i = 0; i < BUMPER_COUNT; i++) begin
      if (POS_W'(i) == mux_position) begin
        bump_hit = 1'b1;
        bump_old = bumper_last[i];
      end
    end
    for (int i = 0; i < BEACON_COUNT; i++) begin
      if (POS_W'(i) == mux_position) begin
        beacon_hit = 1'b1;
        beacon_old = beacon_last[i];
      end
    end
    beacon_found = beacon_hit && (beacon_sample > beacon_high) && (beacon_old < beacon_high);
    beacon_lost  = beacon_hit && !beacon_found && (beacon_sample < beacon_low)
                   && (beacon_old > beacon_low);
  end

  // Tape lanes: each sensor's lit-minus-dark difference runs its own test.
  always_comb begin
    for (int i = 0; i < TAPE_COUNT; i++) begin
      tape_diff[i]  = $signed({1'b0, tape_lit[i]}) - $signed({1'b0, tape_dark[i]});
      tape_found[i] = (tape_diff[i] > tape_high) && (tape_last_diff[i] < tape_high);
      tape_lost[i]  = !tape_found[i] && (tape_diff[i] < tape_low)
                      && (tape_last_diff[i] > tape_low);
    end
  end

  // Sensor history and scan position.
  always_ff @(posedge clk) begin
    if (rst) begin
      mux_position <= '0;
      led_phase    <= 1'b0;
      for (int i = 0; i < BUMPER_COUNT; i++) begin
        bumper_last[i] <= (i >= BUMPER_MASK_BITS) ? 1'b1 : BUMPER_RESET_MASK[i];
      end
      for (int i = 0; i < BEACON_COUNT; i++) begin
        beacon_last[i] <= '0;
      end
      for (int i = 0; i < TAPE_COUNT; i++) begin
        tape_dark[i]      <= '0;
        tape_lit[i]       <= '0;
        tape_last_diff[i] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        mux_position <= pos_next;
        if (wrap) begin
          led_phase <= ~led_phase;
        end
        for (int i = 0; i < BUMPER_COUNT; i++) begin
          if (POS_W'(i) == mux_position) begin
            bumper_last[i] <= bump_level;
          end
        end
        for (int i = 0; i < BEACON_COUNT; i++) begin
          if (POS_W'(i) == mux_position) begin
            beacon_last[i] <= beacon_sample;
          end
        end
        for (int i = 0; i < TAPE_COUNT; i++) begin
          if (POS_W'(i) == mux_position) begin
            if (led_phase) begin
              tape_lit[i] <= tape_sample;
            end else begin
              tape_dark[i] <= tape_sample;
            end
          end
        end
      end
      if (cmd.tape_eval) begin
        for (int i = 0; i < TAPE_COUNT; i++) begin
          tape_last_diff[i] <= tape_diff[i];
        end
      end
    end
  end

  // Pending events, one bit per source; the bumper sits in bit 0, the beacon in bit 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      emit_count <= '0;
    end else begin
      if (cmd.accept) begin
        pending    <= {{(NSRC - 2){1'b0}}, beacon_found || beacon_lost,
                       bump_hit && (bump_level != bump_old)};
        emit_count <= '0;
      end else if (cmd.tape_eval) begin
        for (int i = 0; i < TAPE_COUNT; i++) begin
          pending[SRC_TAPE0 + i] <= tape_found[i] || tape_lost[i];
        end
      end else if (cmd.emit) begin
        pending    <= rest;
        emit_count <= emit_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_pos                <= mux_position;
      src_kind[SRC_BUMP]     <= bump_level ? EV_BUMP_RELEASE : EV_BUMP_TRIP;
      src_kind[SRC_BEACON]   <= beacon_found ? EV_BEACON_FOUND : EV_BEACON_LOST;
    end
    if (cmd.tape_eval) begin
      for (int i = 0; i < TAPE_COUNT; i++) begin
        src_kind[SRC_TAPE0 + i] <= tape_found[i] ? EV_TAPE_FOUND : EV_TAPE_LOST;
      end
    end
  end

  // Lowest pending source goes out next; with nothing pending a none word goes out.
  always_comb begin
    sel_found = 1'b0;
    sel_kind  = EV_NONE;
    sel_num   = '0;
    rest      = pending;
    for (int i = 0; i < NSRC; i++) begin
      if (pending[i] && !sel_found) begin
        sel_found = 1'b1;
        sel_kind  = src_kind[i];
        sel_num   = (i < SRC_TAPE0) ? acc_pos : NUM_W'(i - SRC_TAPE0);
        rest[i]   = 1'b0;
      end
    end
    item_last = (rest == '0) || (emit_count == CNT_W'(MAX_RESULTS - 1));
  end

  always_comb begin
    status.wrap      = wrap;
    status.out_free  = !out_valid || !out_stall;
    status.item_last = item_last;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_kind    <= sel_kind;
      sensor_number <= sel_num;
      mux_select    <= mux_position;
      leds_on       <= led_phase;
      last          <= item_last;
    end
  end

`ifndef SYNTH
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (emit_count == '0))
    else $error("emit count not cleared on a new word");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !item_last) |=> (pending != '0))
    else $error("non-final word left no pending event");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.accept |=> $stable(mux_position))
    else $error("mux position moved without an accepted word");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (pending == '0)) |=> (last && (event_kind == EV_NONE)))
    else $error("none word not marked last");
`endif

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the multiplexed sensor event scanner
// A directed table of read slots, then random slots under several threshold
// settings, with random idling on both sides and one long output hold.
// Every result word is checked against its directed row or a behavioral model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import mses_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    event_kind_t      kind;
    logic [NUM_W-1:0] num;
    logic [POS_W-1:0] mux;
    logic             leds;
    logic             last;
  } scan_event_t;

  // One row of the directed table. Rows with known set carry the single
  // result word the slot must produce.
  typedef struct packed {
    logic                   bump;
    logic [SAMPLE_BITS-1:0] beacon;
    logic [SAMPLE_BITS-1:0] tape;
    logic                   known;
    event_kind_t            kind;
    logic [NUM_W-1:0]       num;
    logic [POS_W-1:0]       mux;
    logic                   leds;
  } slot_row_t;

  localparam int SLOT_ROWS = 20;

  slot_row_t slot_table [SLOT_ROWS] = '{
    '{1'b1, 10'd0,    10'd0,    1'b1, EV_NONE,         3'd0, 3'd1, 1'b0},
    '{1'b0, 10'd1023, 10'd1023, 1'b0, EV_NONE,         3'd0, 3'd0, 1'b0},
    '{1'b1, 10'd700,  10'd0,    1'b1, EV_BEACON_FOUND, 3'd2, 3'd3, 1'b0},
    '{1'b0, 10'd0,    10'd0,    1'b1, EV_BUMP_TRIP,    3'd3, 3'd4, 1'b0},
    '{1'b0, 10'd1023, 10'd0,    1'b1, EV_BUMP_TRIP,    3'd4, 3'd0, 1'b1},
    '{1'b1, 10'd0,    10'd1023, 1'b1, EV_NONE,         3'd0, 3'd1, 1'b1},
    '{1'b1, 10'd0,    10'd1023, 1'b0, EV_NONE,         3'd0, 3'd0, 1'b0},
    '{1'b0, 10'd300,  10'd1023, 1'b0, EV_NONE,         3'd0, 3'd0, 1'b0},
    '{1'b1, 10'd1023, 10'd1023, 1'b0, EV_NONE,         3'd0, 3'd0, 1'b0},
    '{1'b1, 10'd0,    10'd1023, 1'b0, EV_NONE,         3'd0, 3'd0, 1'b0},
    '{1'b1, 10'd512,  10'd1023, 1'b1, EV_NONE,         3'd0, 3'd1, 1'b0},
    '{1'b1, 10'd601,  10'd0,    1'b1, EV_BEACON_FOUND, 3'd1, 3'd2, 1'b0},
    '{1'b0, 10'd600,  10'd1023, 1'b1, EV_NONE,         3'd0, 3'd3, 1'b0},
    '{1'b1, 10'd399,  10'd1023, 1'b1, EV_BEACON_LOST,  3'd3, 3'd4, 1'b0},
    '{1'b0, 10'd0,    10'd1023, 1'b0, EV_NONE,         3'd0, 3'd0, 1'b0},
    '{1'b1, 10'd512,  10'd0,    1'b1, EV_NONE,         3'd0, 3'd1, 1'b1},
    '{1'b1, 10'd1023, 10'd512,  1'b1, EV_NONE,         3'd0, 3'd2, 1'b1},
    '{1'b0, 10'd1023, 10'd0,    1'b1, EV_NONE,         3'd0, 3'd3, 1'b1},
    '{1'b1, 10'd399,  10'd0,    1'b1, EV_NONE,         3'd0, 3'd4, 1'b1},
    '{1'b0, 10'd0,    10'd1023, 1'b1, EV_NONE,         3'd0, 3'd0, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_BEACON_HIGH;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   bump_level = 1'b1;
  logic [SAMPLE_BITS-1:0] beacon_sample = '0;
  logic [SAMPLE_BITS-1:0] tape_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             event_kind;
  logic [NUM_W-1:0]       sensor_number;
  logic [POS_W-1:0]       mux_select;
  logic                   leds_on;
  logic                   last;

  muxed_sensor_event_scanner_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .bump_level(bump_level), .beacon_sample(beacon_sample), .tape_sample(tape_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .sensor_number(sensor_number),
    .mux_select(mux_select), .leds_on(leds_on), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("muxed_sensor_event_scanner_unit test failed");
    $finish;
  end

  // Scanner model state and its copy of the thresholds.
  logic [SAMPLE_BITS-1:0] beacon_high = BEACON_HIGH_RESET;
  logic [SAMPLE_BITS-1:0] beacon_low = BEACON_LOW_RESET;
  int                     tape_high = 200;
  int                     tape_low = 100;
  logic [POS_W-1:0]       mux_pos = '0;
  logic                   led_lit = 1'b0;
  logic                   bump_seen [BUMPER_COUNT] = '{default: 1'b1};
  logic [SAMPLE_BITS-1:0] beacon_seen [BEACON_COUNT] = '{default: '0};
  logic [SAMPLE_BITS-1:0] tape_dark [TAPE_COUNT] = '{default: '0};
  logic [SAMPLE_BITS-1:0] tape_lit [TAPE_COUNT] = '{default: '0};
  int                     tape_diff [TAPE_COUNT] = '{default: 0};

  scan_event_t slot_events [$];
  scan_event_t pending_events [$];
  scan_event_t want;
  int          mismatches = 0;
  int          words_seen = 0;
  int          slots_sent = 0;

  function automatic void note_event(event_kind_t kind, int num);
    scan_event_t ev;
    ev.kind = kind;
    ev.num  = num[NUM_W-1:0];
    ev.mux  = '0;
    ev.leds = 1'b0;
    ev.last = 1'b0;
    if (slot_events.size() < MAX_RESULTS) slot_events.push_back(ev);
  endfunction

  // Advances the model by one read slot; keep moves its words onto the
  // pending list.
  task automatic scan_slot(input logic bump, input logic [SAMPLE_BITS-1:0] bcn,
                           input logic [SAMPLE_BITS-1:0] tp, input bit keep);
    int p;
    int d;
    scan_event_t ev;
    slot_events.delete();
    p = int'(mux_pos);
    if (p < BUMPER_COUNT && bump != bump_seen[p]) begin
      note_event(bump ? EV_BUMP_RELEASE : EV_BUMP_TRIP, p);
      bump_seen[p] = bump;
    end
    if (p < BEACON_COUNT) begin
      if (bcn > beacon_high && beacon_seen[p] < beacon_high) begin
        note_event(EV_BEACON_FOUND, p);
      end else if (bcn < beacon_low && beacon_seen[p] > beacon_low) begin
        note_event(EV_BEACON_LOST, p);
      end
      beacon_seen[p] = bcn;
    end
    if (p < TAPE_COUNT) begin
      if (led_lit) tape_lit[p] = tp;
      else tape_dark[p] = tp;
    end
    mux_pos = POS_W'((p + 1) % MUX_POSITIONS);
    // The wrap slot flips the LEDs and tests every tape difference.
    if (mux_pos == 0) begin
      led_lit = !led_lit;
      for (int i = 0; i < TAPE_COUNT; i++) begin
        d = int'(tape_lit[i]) - int'(tape_dark[i]);
        if (d > tape_high && tape_diff[i] < tape_high) begin
          note_event(EV_TAPE_FOUND, i);
        end else if (d < tape_low && tape_diff[i] > tape_low) begin
          note_event(EV_TAPE_LOST, i);
        end
        tape_diff[i] = d;
      end
    end
    if (slot_events.size() == 0) note_event(EV_NONE, 0);
    for (int k = 0; k < slot_events.size(); k++) begin
      ev = slot_events[k];
      ev.mux = mux_pos;
      ev.leds = led_lit;
      ev.last = (k == slot_events.size() - 1);
      slot_events[k] = ev;
      if (keep) pending_events.push_back(ev);
    end
  endtask

  task automatic write_threshold(input cfg_reg_t idx, input int val);
    logic [CFG_W-1:0] v;
    v = val[CFG_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_BEACON_HIGH: beacon_high = v[SAMPLE_BITS-1:0];
      REG_BEACON_LOW:  beacon_low = v[SAMPLE_BITS-1:0];
      REG_TAPE_HIGH:   tape_high = int'($signed(v));
      REG_TAPE_LOW:    tape_low = int'($signed(v));
      default: ;
    endcase
  endtask

  // Offers one read slot and returns at the edge where it is taken. Valid
  // stays high afterwards, so the caller either offers again or goes idle.
  task automatic offer_slot(input logic bump, input logic [SAMPLE_BITS-1:0] bcn,
                            input logic [SAMPLE_BITS-1:0] tp);
    bit calm;
    calm = (slots_sent >= 200 && slots_sent < 290);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    bump_level    <= bump;
    beacon_sample <= bcn;
    tape_sample   <= tp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    slots_sent++;
  endtask

  task automatic go_idle_and_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic run_random(input int bh, input int bl, input int th, input int tl,
                            input int count);
    logic                   b;
    logic [SAMPLE_BITS-1:0] bc;
    logic [SAMPLE_BITS-1:0] tp;
    write_threshold(REG_BEACON_HIGH, bh);
    write_threshold(REG_BEACON_LOW, bl);
    write_threshold(REG_TAPE_HIGH, th);
    write_threshold(REG_TAPE_LOW, tl);
    repeat (count) begin
      b  = 1'($urandom_range(0, 1));
      bc = pick_sample();
      tp = pick_sample();
      offer_slot(b, bc, tp);
      scan_slot(b, bc, tp, 1'b1);
    end
    go_idle_and_drain();
  endtask

  initial begin
    scan_event_t ev;
    slot_row_t   row;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SLOT_ROWS; i++) begin
      row = slot_table[i];
      offer_slot(row.bump, row.beacon, row.tape);
      scan_slot(row.bump, row.beacon, row.tape, !row.known);
      if (row.known) begin
        ev.kind = row.kind;
        ev.num  = row.num;
        ev.mux  = row.mux;
        ev.leds = row.leds;
        ev.last = 1'b1;
        pending_events.push_back(ev);
      end
    end
    go_idle_and_drain();

    run_random($urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 2046) - 1023, $urandom_range(0, 2046) - 1023, 80);
    run_random(0, 1023, 1023, -1023, 40);
    run_random(1022, 1, 1022, -1022, 60);
    run_random(1023, 0, -1023, 1023, 40);
    run_random(512, 511, 0, -1, 100);
    run_random($urandom_range(300, 700), $urandom_range(200, 500),
               $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200, 80);

    if (mismatches == 0) begin
      $display("muxed_sensor_event_scanner_unit test passed");
    end else begin
      $display("muxed_sensor_event_scanner_unit test failed");
    end
    $finish;
  end

  // Output stall: random, with one long hold that backs the block up, and a
  // calm window with no stalls at all.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held && words_seen >= 120) begin
        held = 1'b1;
        hold_left = 250;
        out_stall <= 1'b1;
      end else if (words_seen >= 350 && words_seen < 480) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 7);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d arrived with nothing pending: kind %0d num %0d",
                   words_seen, event_kind, sensor_number);
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind || sensor_number !== want.num ||
            mux_select !== want.mux || leds_on !== want.leds || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %0d: got kind %0d num %0d mux %0d leds %0b last %0b, %s",
                     words_seen, event_kind, sensor_number, mux_select, leds_on, last,
                     $sformatf("expected kind %0d num %0d mux %0d leds %0b last %0b",
                               want.kind, want.num, want.mux, want.leds, want.last));
        end
      end
    end
  end

endmodule

`default_nettype wire
